@@ rtl/ptt_pkg.sv @@
// Shared types and constants for the periodic task timer table.
// No dependencies.
package ptt_pkg;

  typedef enum logic [3:0] {
    ACT_ADD_DEF   = 4'd0,
    ACT_ADD_IMM   = 4'd1,
    ACT_CLR_DEF   = 4'd2,
    ACT_CLR_IMM   = 4'd3,
    ACT_TICK      = 4'd4,
    ACT_PROCESS   = 4'd5,
    ACT_REMOVE    = 4'd6,
    ACT_PAUSE     = 4'd7,
    ACT_RESUME    = 4'd8,
    ACT_SET_PER   = 4'd9
  } action_t;

  // Input word.
  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  task_id;
    logic [15:0] period_ticks;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        is_fire;
    logic [7:0]  fired_task;
    logic        from_immediate;
    logic [4:0]  slot_index;
    logic        accepted;
    logic        last_result;
  } out_word_t;

  // One table entry as held in memory.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [15:0] counter;
    logic        running;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage

@@ rtl/ptt_if.sv @@
// Valid/ready channel interfaces for input and result words.
// Depends on ptt_pkg.
interface ptt_in_if (input logic clk);
  import ptt_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptt_out_if (input logic clk);
  import ptt_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ptt_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/periodic_task_timer_table_top.sv @@
// Top level of the periodic task timer table: sequencer and two entry RAMs.
// Depends on ptt_pkg, ptt_if and ptt_ram.
//
//  channel | direction | word
//  in      | sink      | action, task_id, period_ticks
//  out     | source    | is_fire, fired_task, from_immediate, slot_index, accepted, last_result
//
// One word at a time. Add, clear and unknown actions finish in the accepting cycle and
// their status word is valid on the next. Tick, remove, pause, resume and set period walk
// both tables and process the deferred one. Each entry takes a read step (S_READ) and an
// evaluate step (S_EVAL), since the RAM read is registered; each table walked ends with a
// range check in S_READ, and S_DONE sends the status word. A stalled result word holds
// the walk and blocks the input. Reset clears only the entry counts and the sequencer;
// no clearing pass.
module periodic_task_timer_table_top #(
  parameter int DEFERRED_SLOTS  = 16,
  parameter int IMMEDIATE_SLOTS = 16
) (
  input logic clk,
  input logic rst_n,
  ptt_in_if.sink    in_ch,
  ptt_out_if.source out_ch
);
  import ptt_pkg::*;

  localparam int MAXS = (DEFERRED_SLOTS > IMMEDIATE_SLOTS) ? DEFERRED_SLOTS : IMMEDIATE_SLOTS;
  localparam int AW   = (MAXS > 1) ? $clog2(MAXS) : 1;
  localparam int CW   = $clog2(MAXS + 1);
  localparam int DAW  = (DEFERRED_SLOTS > 1) ? $clog2(DEFERRED_SLOTS) : 1;
  localparam int IAW  = (IMMEDIATE_SLOTS > 1) ? $clog2(IMMEDIATE_SLOTS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_SHIFT, S_EMIT, S_DONE} state_t;

  state_t    state_r;
  in_word_t  cmd_r;
  logic      tab_r;          // 0 deferred, 1 immediate
  logic [CW-1:0] idx_r;      // walk position
  logic      found_r;        // remove: match found, now compacting
  logic      hit_r;
  logic [CW-1:0] dcnt_r, icnt_r;
  out_word_t obuf_r;
  logic      ovalid_r;

  // RAM ports
  logic          d_we, i_we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, d_rdata, i_rdata;

  ptt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEFERRED_SLOTS)) u_def (
    .clk(clk), .we(d_we), .waddr(waddr[DAW-1:0]), .wdata(wdata),
    .raddr(raddr[DAW-1:0]), .rdata(d_rdata));
  ptt_ram #(.WIDTH(ENTRY_W), .DEPTH(IMMEDIATE_SLOTS)) u_imm (
    .clk(clk), .we(i_we), .waddr(waddr[IAW-1:0]), .wdata(wdata),
    .raddr(raddr[IAW-1:0]), .rdata(i_rdata));

  logic [CW-1:0] cur_cnt;
  entry_t        rd;
  logic          out_free;
  assign cur_cnt = tab_r ? icnt_r : dcnt_r;
  assign rd      = tab_r ? i_rdata : d_rdata;
  assign out_free = !ovalid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = obuf_r;
  assign raddr = idx_r[AW-1:0];

  // Entry modification for the current walk step.
  entry_t mod;
  logic   fire, match, wr;
  always_comb begin
    mod   = rd;
    fire  = 1'b0;
    match = (rd.id == cmd_r.task_id);
    wr    = 1'b0;
    unique case (cmd_r.action)
      ACT_TICK: begin
        if ((!tab_r && rd.running) || tab_r) begin
          if (rd.counter != CNT_MAX) mod.counter = rd.counter + 16'd1;
        end
        wr = 1'b1;
        if (tab_r && mod.counter >= rd.period) begin
          mod.counter = '0;
          fire = 1'b1;
        end
      end
      ACT_PROCESS: begin
        wr = 1'b1;
        if (rd.counter >= rd.period) begin
          mod.counter = '0;
          fire = 1'b1;
        end
      end
      ACT_PAUSE:   begin wr = match; mod.running = 1'b0; end
      ACT_RESUME:  begin wr = match; mod.running = 1'b1; end
      ACT_SET_PER: begin wr = match; mod.period = cmd_r.period_ticks; end
      default: ;
    endcase
  end

  // RAM write steering.
  always_comb begin
    d_we  = 1'b0;
    i_we  = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = mod;
    if (state_r == S_IDLE && in_ch.valid && out_free) begin
      wdata = '{id: in_ch.data.task_id, period: in_ch.data.period_ticks,
                counter: 16'd0, running: 1'b1};
      if (in_ch.data.action == ACT_ADD_DEF) begin
        waddr = dcnt_r[AW-1:0];
        d_we  = (in_ch.data.period_ticks != 0) && (dcnt_r < CW'(DEFERRED_SLOTS));
      end else if (in_ch.data.action == ACT_ADD_IMM) begin
        waddr = icnt_r[AW-1:0];
        i_we  = (in_ch.data.period_ticks != 0) && (icnt_r < CW'(IMMEDIATE_SLOTS));
      end
    end else if (state_r == S_EVAL && out_free) begin
      if (cmd_r.action == ACT_REMOVE) begin
        // compaction copies entry idx into idx-1
        waddr = AW'(idx_r - CW'(1));
        wdata = rd;
        d_we  = found_r && !tab_r;
        i_we  = found_r && tab_r;
      end else begin
        d_we = wr && !tab_r;
        i_we = wr && tab_r;
      end
    end
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      dcnt_r   <= '0;
      icnt_r   <= '0;
      tab_r    <= 1'b0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && out_free) begin
            cmd_r   <= in_ch.data;
            idx_r   <= '0;
            found_r <= 1'b0;
            hit_r   <= 1'b0;
            tab_r   <= (in_ch.data.action == ACT_TICK) && (dcnt_r == 0);
            case (in_ch.data.action) inside
              ACT_ADD_DEF, ACT_ADD_IMM: begin
                obuf_r <= '{is_fire: 1'b0, fired_task: in_ch.data.task_id,
                  from_immediate: in_ch.data.action[0],
                  slot_index: 5'(in_ch.data.action[0] ? icnt_r : dcnt_r),
                  accepted: d_we || i_we, last_result: 1'b1};
                ovalid_r <= 1'b1;
                if (d_we) dcnt_r <= dcnt_r + CW'(1);
                if (i_we) icnt_r <= icnt_r + CW'(1);
              end
              ACT_CLR_DEF, ACT_CLR_IMM: begin
                obuf_r <= '{default: '0, last_result: 1'b1};
                ovalid_r <= 1'b1;
                if (in_ch.data.action == ACT_CLR_DEF) dcnt_r <= '0;
                else icnt_r <= '0;
              end
              ACT_TICK, ACT_PROCESS, ACT_REMOVE, ACT_PAUSE, ACT_RESUME, ACT_SET_PER:
                state_r <= S_READ;
              default: begin
                obuf_r <= '{default: '0, last_result: 1'b1};
                ovalid_r <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          // address idx_r is presented; check range first
          if (idx_r >= cur_cnt) begin
            if (found_r) begin
              if (tab_r) icnt_r <= icnt_r - CW'(1);
              else dcnt_r <= dcnt_r - CW'(1);
            end
            found_r <= 1'b0;
            idx_r   <= '0;
            if (!tab_r && cmd_r.action != ACT_PROCESS) tab_r <= 1'b1;
            else state_r <= S_DONE;
          end else begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            state_r <= S_READ;
            idx_r   <= idx_r + CW'(1);
            if (cmd_r.action == ACT_REMOVE) begin
              if (!found_r && match) begin
                found_r <= 1'b1;
                hit_r   <= 1'b1;
              end
            end else begin
              if (match) hit_r <= 1'b1;
              if (fire) begin
                obuf_r <= '{is_fire: 1'b1, fired_task: rd.id, from_immediate: tab_r,
                  slot_index: 5'(idx_r), accepted: 1'b0, last_result: 1'b0};
                ovalid_r <= 1'b1;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (cmd_r.action == ACT_TICK || cmd_r.action == ACT_PROCESS)
              obuf_r <= '{default: '0, last_result: 1'b1};
            else
              obuf_r <= '{is_fire: 1'b0, fired_task: cmd_r.task_id, from_immediate: 1'b0,
                slot_index: 5'd0, accepted: hit_r, last_result: 1'b1};
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Entry counts never exceed table sizes.
  a_dcnt: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= CW'(DEFERRED_SLOTS)) else $error("deferred count overflow");
  a_icnt: assert property (@(posedge clk) disable iff (!rst_n)
    icnt_r <= CW'(IMMEDIATE_SLOTS)) else $error("immediate count overflow");
  // A word accepted while busy is impossible.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  // Closing status ends the walk.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (ovalid_r && obuf_r.last_result))
    else $error("missing closing word");
endmodule
